[design/srng_pkg.sv]
// Shared request codes and controller/datapath handshake types for the sequenced overwrite ring.
package srng_pkg;

  localparam logic [2:0] REQ_PUSH    = 3'd0;
  localparam logic [2:0] REQ_RESERVE = 3'd1;
  localparam logic [2:0] REQ_COMMIT  = 3'd2;
  localparam logic [2:0] REQ_READ    = 3'd3;
  localparam logic [2:0] REQ_ATTACH  = 3'd4;
  localparam logic [2:0] REQ_SETPOS  = 3'd5;

  typedef struct packed {
    logic exec;       // Execute a non-read request and load the result register.
    logic rd_issue;   // Start a slot memory read at the head slot.
    logic rd_finish;  // Resolve the read from the registered memory data.
    logic clr_step;   // Clear one slot's valid mark after reset.
  } cmd_t;

  typedef struct packed {
    logic clr_last;   // The clearing pass is at its final slot.
  } stat_t;

endpackage

[design/srng_ctrl.sv]
// Controller state machine: clearing pass, request sequencing and result handshake.
module srng_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [2:0]      in_req_type,
  output logic            out_valid,
  input  logic            out_ready,
  output srng_pkg::cmd_t  cmd,
  input  srng_pkg::stat_t stat
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_req_type == srng_pkg::REQ_READ) begin
            cmd.rd_issue = 1'b1;
            state_nxt    = ST_READ;
          end else begin
            cmd.exec      = 1'b1;
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_READ: begin
        // The result register was freed when the read was accepted.
        cmd.rd_finish = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[design/srng_dp.sv]
// Datapath: tail and head counters, slot memories and the result register.
module srng_dp #(
  parameter int SLOTS     = 1024,
  parameter int DATA_BITS = 64,
  parameter int SEQ_BITS  = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  srng_pkg::cmd_t  cmd,
  output srng_pkg::stat_t stat,
  input  logic [2:0]      in_req_type,
  input  logic [63:0]     in_data_in,
  input  logic [31:0]     in_seq_in,
  output logic            out_ok,
  output logic [63:0]     out_data_out,
  output logic [31:0]     out_seq_out,
  output logic [9:0]      out_slot_out
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam logic [SEQ_BITS-1:0] SEQ_MAX = '1;
  localparam logic [SEQ_BITS-1:0] SEQ_ONE = SEQ_BITS'(1);
  localparam logic [SLOT_W-1:0]   SLOT_ONE = SLOT_W'(1);

  // Each stamp entry carries its valid mark in the top bit.
  logic [DATA_BITS-1:0] data_mem  [SLOTS];
  logic [SEQ_BITS:0]    stamp_mem [SLOTS];

  logic [SEQ_BITS-1:0]  tail_r, tail_nxt;
  logic [SEQ_BITS-1:0]  head_r, head_nxt;
  logic [SLOT_W-1:0]    clr_cnt_r, clr_cnt_nxt;

  logic [DATA_BITS-1:0] rd_data_r;
  logic [SEQ_BITS:0]    rd_stamp_r;

  logic                 res_ok_r, res_ok_nxt;
  logic [DATA_BITS-1:0] res_data_r, res_data_nxt;
  logic [SEQ_BITS-1:0]  res_seq_r, res_seq_nxt;
  logic [SLOT_W-1:0]    res_slot_r, res_slot_nxt;

  logic                 mem_we;
  logic [SLOT_W-1:0]    wr_addr;
  logic [DATA_BITS-1:0] wr_data;
  logic [SEQ_BITS:0]    wr_stamp;

  logic [DATA_BITS-1:0] data_k;
  logic [63:0]          seq_in_ext;
  logic [SEQ_BITS-1:0]  seq_k;
  logic [63:0]          seq_k_ext, tail_ext, head_ext;
  logic [SLOT_W-1:0]    seq_slot, tail_slot, head_slot;
  logic                 tail_full;
  logic [SEQ_BITS-1:0]  rd_stamp;
  logic                 rd_ready;
  logic [63:0]          res_seq_ext, res_slot_ext;

  assign data_k     = in_data_in[DATA_BITS-1:0];
  assign seq_in_ext = 64'(in_seq_in);
  assign seq_k      = seq_in_ext[SEQ_BITS-1:0];
  assign seq_k_ext  = 64'(seq_k);
  assign tail_ext   = 64'(tail_r);
  assign head_ext   = 64'(head_r);
  assign seq_slot   = seq_k_ext[SLOT_W-1:0];
  assign tail_slot  = tail_ext[SLOT_W-1:0];
  assign head_slot  = head_ext[SLOT_W-1:0];
  assign tail_full  = (tail_r == SEQ_MAX);

  assign rd_stamp   = rd_stamp_r[SEQ_BITS-1:0];
  assign rd_ready   = (head_r < tail_r) && rd_stamp_r[SEQ_BITS] && (rd_stamp >= head_r);

  assign stat.clr_last = &clr_cnt_r;

  always_comb begin
    tail_nxt     = tail_r;
    head_nxt     = head_r;
    clr_cnt_nxt  = clr_cnt_r;
    res_ok_nxt   = res_ok_r;
    res_data_nxt = res_data_r;
    res_seq_nxt  = res_seq_r;
    res_slot_nxt = res_slot_r;
    mem_we       = 1'b0;
    wr_addr      = clr_cnt_r;
    wr_data      = '0;
    wr_stamp     = '0;

    if (cmd.clr_step) begin
      mem_we      = 1'b1;
      clr_cnt_nxt = clr_cnt_r + SLOT_ONE;
    end

    if (cmd.exec) begin
      res_ok_nxt   = 1'b1;
      res_data_nxt = '0;
      unique case (in_req_type) inside
        srng_pkg::REQ_PUSH, srng_pkg::REQ_RESERVE: begin
          res_seq_nxt  = tail_r;
          res_slot_nxt = tail_slot;
          if (tail_full) begin
            res_ok_nxt = 1'b0;
          end else begin
            tail_nxt = tail_r + SEQ_ONE;
            if (in_req_type == srng_pkg::REQ_PUSH) begin
              mem_we   = 1'b1;
              wr_addr  = tail_slot;
              wr_data  = data_k;
              wr_stamp = {1'b1, tail_r};
            end
          end
        end
        srng_pkg::REQ_COMMIT: begin
          res_seq_nxt  = seq_k;
          res_slot_nxt = seq_slot;
          mem_we       = 1'b1;
          wr_addr      = seq_slot;
          wr_data      = data_k;
          wr_stamp     = {1'b1, seq_k};
        end
        srng_pkg::REQ_ATTACH: begin
          head_nxt     = tail_r;
          res_seq_nxt  = tail_r;
          res_slot_nxt = tail_slot;
        end
        srng_pkg::REQ_SETPOS: begin
          head_nxt     = seq_k;
          res_seq_nxt  = seq_k;
          res_slot_nxt = seq_slot;
        end
        default: begin
          res_ok_nxt   = 1'b0;
          res_seq_nxt  = '0;
          res_slot_nxt = '0;
        end
      endcase
    end

    if (cmd.rd_finish) begin
      res_slot_nxt = head_slot;
      if (rd_ready) begin
        res_ok_nxt   = 1'b1;
        res_data_nxt = rd_data_r;
        res_seq_nxt  = rd_stamp;
        // A lapped reader jumps past the newer stamp; head saturates at the top.
        head_nxt     = (rd_stamp == SEQ_MAX) ? SEQ_MAX : rd_stamp + SEQ_ONE;
      end else begin
        res_ok_nxt   = 1'b0;
        res_data_nxt = '0;
        res_seq_nxt  = head_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_r    <= '0;
      head_r    <= '0;
      clr_cnt_r <= '0;
    end else begin
      tail_r    <= tail_nxt;
      head_r    <= head_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_ok_r   <= res_ok_nxt;
    res_data_r <= res_data_nxt;
    res_seq_r  <= res_seq_nxt;
    res_slot_r <= res_slot_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      data_mem[wr_addr]  <= wr_data;
      stamp_mem[wr_addr] <= wr_stamp;
    end
    if (cmd.rd_issue) begin
      rd_data_r  <= data_mem[head_slot];
      rd_stamp_r <= stamp_mem[head_slot];
    end
  end

  assign res_seq_ext  = 64'(res_seq_r);
  assign res_slot_ext = 64'(res_slot_r);

  assign out_ok       = res_ok_r;
  assign out_data_out = 64'(res_data_r);
  assign out_seq_out  = res_seq_ext[31:0];
  assign out_slot_out = res_slot_ext[9:0];

endmodule

[design/sequenced_overwrite_ring.sv]
// Top level of the sequenced overwrite ring: controller, datapath and checks.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+----------------------------------------------
//   in      | in_valid / in_ready  | in_req_type, in_data_in, in_seq_in
//   out     | out_valid / out_ready| out_ok, out_data_out, out_seq_out, out_slot_out
//
// A read passes through a registered slot memory access and then the head
// check; every other request executes directly into the result register.
// After reset the block clears every slot's valid mark, one slot a cycle, and
// takes no item until the clearing pass ends.
// A finished result sits in the output register; a new item is taken in the same
// cycle the waiting result is taken, so a stalled output stalls the input.
module sequenced_overwrite_ring #(
  parameter int SLOTS     = 1024,
  parameter int DATA_BITS = 64,
  parameter int SEQ_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [63:0] in_data_in,
  input  logic [31:0] in_seq_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ok,
  output logic [63:0] out_data_out,
  output logic [31:0] out_seq_out,
  output logic [9:0]  out_slot_out
);

  srng_pkg::cmd_t  cmd;
  srng_pkg::stat_t stat;

  srng_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cmd         (cmd),
    .stat        (stat)
  );

  srng_dp #(
    .SLOTS     (SLOTS),
    .DATA_BITS (DATA_BITS),
    .SEQ_BITS  (SEQ_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_req_type  (in_req_type),
    .in_data_in   (in_data_in),
    .in_seq_in    (in_seq_in),
    .out_ok       (out_ok),
    .out_data_out (out_data_out),
    .out_seq_out  (out_seq_out),
    .out_slot_out (out_slot_out)
  );

  // Only one datapath action can happen in any cycle.
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.exec, cmd.rd_issue, cmd.rd_finish, cmd.clr_step}))
    else $error("more than one datapath command in a cycle");

  // A started read always resolves in the following cycle.
  a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |=> cmd.rd_finish)
    else $error("slot read did not complete");

  // A resolved read or executed request always presents a result.
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_finish || cmd.exec) |=> out_valid)
    else $error("request finished without a result");

  // No item is taken while the clearing pass runs.
  a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_step |-> !in_ready)
    else $error("input ready during clearing pass");

endmodule

[tb/sv/sequenced_overwrite_ring_test.sv]
// Self-checking testbench for the sequenced overwrite ring with a scoreboard class.
module sequenced_overwrite_ring_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SLOTS          = 1024;
  localparam int          DATA_BITS      = 64;
  localparam int          SEQ_BITS       = 32;
  localparam int          SLOT_BITS      = 10;
  localparam logic [31:0] SEQ_TOP        = '1;
  localparam int          RANDOM_ITEMS   = 1020;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          DRAIN_CYCLES   = 20;
  localparam int          WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic        ok;
    logic [63:0] data;
    logic [31:0] seq;
    logic [9:0]  slot;
  } ring_result_t;

  class ring_scoreboard;
    bit [31:0]    tail_seq;
    bit [31:0]    read_head;
    bit [63:0]    slot_word [SLOTS];
    bit [31:0]    slot_stamp [SLOTS];
    bit           slot_filled [SLOTS];
    ring_result_t pending_results [$];
    int unsigned  mismatches;

    // Advances the ring state for one accepted item and queues its result.
    function void note_request(logic [2:0] req, logic [63:0] data, logic [31:0] seq);
      ring_result_t res;
      bit [SLOT_BITS-1:0] idx;
      res = '0;
      case (req)
        srng_pkg::REQ_PUSH, srng_pkg::REQ_RESERVE: begin
          idx = tail_seq[SLOT_BITS-1:0];
          res.seq = tail_seq;
          res.slot = idx;
          if (tail_seq != SEQ_TOP) begin
            if (req == srng_pkg::REQ_PUSH) begin
              slot_word[idx] = data;
              slot_stamp[idx] = tail_seq;
              slot_filled[idx] = 1'b1;
            end
            res.ok = 1'b1;
            tail_seq = tail_seq + 1;
          end
        end
        srng_pkg::REQ_COMMIT: begin
          idx = seq[SLOT_BITS-1:0];
          slot_word[idx] = data;
          slot_stamp[idx] = seq;
          slot_filled[idx] = 1'b1;
          res.ok = 1'b1;
          res.seq = seq;
          res.slot = idx;
        end
        srng_pkg::REQ_READ: begin
          idx = read_head[SLOT_BITS-1:0];
          res.slot = idx;
          if (read_head < tail_seq && slot_filled[idx] && slot_stamp[idx] >= read_head) begin
            res.ok = 1'b1;
            res.data = slot_word[idx];
            res.seq = slot_stamp[idx];
            // A lapped reader jumps past the newer stamp it found.
            read_head = (slot_stamp[idx] == SEQ_TOP) ? SEQ_TOP : slot_stamp[idx] + 1;
          end else begin
            res.seq = read_head;
          end
        end
        srng_pkg::REQ_ATTACH, srng_pkg::REQ_SETPOS: begin
          read_head = (req == srng_pkg::REQ_ATTACH) ? tail_seq : seq;
          res.ok = 1'b1;
          res.seq = read_head;
          res.slot = read_head[SLOT_BITS-1:0];
        end
        default: begin
        end
      endcase
      pending_results.push_back(res);
    endfunction

    function void check_result(logic ok, logic [63:0] data, logic [31:0] seq, logic [9:0] slot);
      ring_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing pending: ok=%b data=%h seq=%h slot=%0d",
                 $time, ok, data, seq, slot);
        return;
      end
      want = pending_results.pop_front();
      if (ok !== want.ok) begin
        mismatches++;
        $display("%0t: ok mismatch: expected %b, actual %b", $time, want.ok, ok);
      end
      if (data !== want.data) begin
        mismatches++;
        $display("%0t: data_out mismatch: expected %h, actual %h", $time, want.data, data);
      end
      if (seq !== want.seq) begin
        mismatches++;
        $display("%0t: seq_out mismatch: expected %h, actual %h", $time, want.seq, seq);
      end
      if (slot !== want.slot) begin
        mismatches++;
        $display("%0t: slot_out mismatch: expected %0d, actual %0d", $time, want.slot, slot);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_req_type;
  logic [63:0] in_data_in;
  logic [31:0] in_seq_in;
  logic        out_valid;
  logic        out_ready;
  logic        out_ok;
  logic [63:0] out_data_out;
  logic [31:0] out_seq_out;
  logic [9:0]  out_slot_out;

  ring_scoreboard sb = new;
  bit             idling = 1'b1;
  bit             hold_request = 1'b0;
  logic [31:0]    open_reservations [$];

  sequenced_overwrite_ring #(
    .SLOTS(SLOTS),
    .DATA_BITS(DATA_BITS),
    .SEQ_BITS(SEQ_BITS)
  ) u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] random_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_request(input logic [2:0] req, input logic [63:0] data,
                              input logic [31:0] seq);
    while (idling && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_data_in  <= data;
    in_seq_in   <= seq;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    sb.note_request(req, data, seq);
  endtask

  task automatic send_random_request();
    int unsigned pick;
    int unsigned idx;
    logic [2:0]  req;
    logic [31:0] seq;
    pick = $urandom_range(0, 99);
    seq = $urandom;
    if (pick < 60) begin
      req = srng_pkg::REQ_PUSH;
    end else if (pick < 70) begin
      req = srng_pkg::REQ_RESERVE;
      if (sb.tail_seq != SEQ_TOP) open_reservations.push_back(sb.tail_seq);
    end else if (pick < 78) begin
      req = srng_pkg::REQ_COMMIT;
      if (open_reservations.size() != 0 && $urandom_range(0, 99) < 70) begin
        idx = $urandom_range(0, open_reservations.size() - 1);
        seq = open_reservations[idx];
        open_reservations.delete(idx);
      end else if ($urandom_range(0, 2) != 0) begin
        seq = sb.tail_seq + $urandom_range(0, 40) - 20;
      end
    end else if (pick < 94) begin
      req = srng_pkg::REQ_READ;
    end else if (pick < 96) begin
      req = srng_pkg::REQ_ATTACH;
    end else if (pick < 99) begin
      req = srng_pkg::REQ_SETPOS;
      // Mostly land behind the tail, often far enough back to be lapped.
      if ($urandom_range(0, 3) != 0) seq = sb.tail_seq - $urandom_range(0, 1500);
    end else begin
      req = 3'($urandom_range(6, 7));
    end
    send_request(req, random_word(), seq);
  endtask

  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        sb.check_result(out_ok, out_data_out, out_seq_out, out_slot_out);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(idling && $urandom_range(0, 99) < 15);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int unsigned n;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_req_type <= srng_pkg::REQ_PUSH;
    in_data_in  <= '0;
    in_seq_in   <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: both data extremes, empty reader, reserve then commit, lapping.
    send_request(srng_pkg::REQ_READ, '0, '0);
    send_request(srng_pkg::REQ_PUSH, '0, '0);
    send_request(srng_pkg::REQ_PUSH, '1, '0);
    send_request(srng_pkg::REQ_READ, '0, '0);
    send_request(srng_pkg::REQ_READ, '0, '0);
    send_request(srng_pkg::REQ_COMMIT, random_word(), 32'd2);
    send_request(srng_pkg::REQ_READ, '0, '0);
    send_request(srng_pkg::REQ_RESERVE, random_word(), '1);
    send_request(srng_pkg::REQ_READ, '0, '0);
    send_request(srng_pkg::REQ_RESERVE, '0, '0);
    send_request(srng_pkg::REQ_COMMIT, random_word(), 32'd3);
    send_request(srng_pkg::REQ_READ, '1, '1);
    send_request(srng_pkg::REQ_COMMIT, random_word(), SEQ_TOP);
    send_request(srng_pkg::REQ_SETPOS, '0, 32'd1023);
    send_request(srng_pkg::REQ_READ, '0, '0);
    send_request(srng_pkg::REQ_SETPOS, '0, 32'd1);
    send_request(srng_pkg::REQ_COMMIT, random_word(), 32'd1025);
    send_request(srng_pkg::REQ_READ, '0, '0);
    send_request(srng_pkg::REQ_ATTACH, '1, '1);
    send_request(srng_pkg::REQ_PUSH, random_word(), '0);
    send_request(srng_pkg::REQ_READ, '0, '0);
    send_request(3'd6, '1, '1);
    send_request(3'd7, random_word(), $urandom);
    send_request(srng_pkg::REQ_SETPOS, '0, SEQ_TOP);
    send_request(srng_pkg::REQ_READ, '0, '0);
    send_request(srng_pkg::REQ_SETPOS, '0, $urandom);
    send_request(srng_pkg::REQ_ATTACH, '0, '0);

    // Random traffic with one long receiver hold and one stretch without idling.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 300) hold_request = 1'b1;
      idling = !(n >= 500 && n < 700);
      send_random_request();
    end

    // A commit with a stamp at the top of the range, then reads from slot 1023.
    send_request(srng_pkg::REQ_COMMIT, random_word(), SEQ_TOP);
    send_request(srng_pkg::REQ_SETPOS, '0, 32'd1023);
    send_request(srng_pkg::REQ_READ, '0, '0);
    send_request(srng_pkg::REQ_READ, '0, '0);
    send_request(srng_pkg::REQ_ATTACH, '0, '0);
    in_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
